@@ hdl/erp_pkg.sv @@
// shared types, constants and helper functions of the edid resolution parser
package erp_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    // byte offsets inside the 128-byte base block
    localparam logic [6:0] STD_FIRST  = 7'd38;
    localparam logic [6:0] STD_LAST   = 7'd53;
    localparam logic [6:0] DESC_FIRST = 7'd54;
    localparam logic [6:0] DESC_END   = 7'd126;
    localparam logic [6:0] DESC_LEN   = 7'd18;

    localparam logic [8:0] X_BIAS       = 9'd31;
    localparam logic [6:0] REFRESH_BASE = 7'd60;
    // floor(w/5) == (w * 6554) >> 15 for every w below 4096 that is a multiple of 8
    localparam logic [12:0] DIV5_MUL   = 13'd6554;
    localparam int          DIV5_SHIFT = 15;

    // standard timing aspect codes
    localparam logic [1:0] ASPECT_16_10 = 2'd0;
    localparam logic [1:0] ASPECT_4_3   = 2'd1;
    localparam logic [1:0] ASPECT_5_4   = 2'd2;
    localparam logic [1:0] ASPECT_16_9  = 2'd3;

    // byte positions inside an 18-byte detailed descriptor
    localparam logic [4:0] DESC_PH_TAG0 = 5'd0;
    localparam logic [4:0] DESC_PH_TAG1 = 5'd1;
    localparam logic [4:0] DESC_PH_HLO  = 5'd2;
    localparam logic [4:0] DESC_PH_HHI  = 5'd4;
    localparam logic [4:0] DESC_PH_VLO  = 5'd5;
    localparam logic [4:0] DESC_PH_VHI  = 5'd7;

    typedef enum logic [1:0] {
        TBL_IDLE,
        TBL_SEARCH,
        TBL_DONE
    } t_tbl_state;

    typedef struct packed {
        logic [11:0] width;
        logic [11:0] height;
        logic [6:0]  refresh;
        logic        detailed;
    } t_timing;

    typedef struct packed {
        t_timing     timing;
        logic        is_new;
        logic [5:0]  entry_index;
        logic        table_full;
    } t_result;

    function automatic logic [11:0] std_height(logic [1:0] aspect, logic [11:0] w);
        logic [24:0] prod;
        logic [11:0] q5;
        logic [15:0] h;
        prod = 25'(w) * 25'(DIV5_MUL);
        q5   = 12'(prod >> DIV5_SHIFT);
        case (aspect)
            ASPECT_16_10: h = 16'(w[11:4]) * 16'd10;
            ASPECT_4_3:   h = 16'(w[11:2]) * 16'd3;
            ASPECT_5_4:   h = 16'(q5) * 16'd4;
            default:      h = 16'(w[11:4]) * 16'd9;
        endcase
        return h[11:0];
    endfunction

    // position inside the descriptor area, offset assumed in 54..125
    function automatic logic [4:0] desc_phase(logic [6:0] off);
        logic [6:0] d;
        d = off - DESC_FIRST;
        for (int i = 0; i < 3; i++) begin
            if (d >= DESC_LEN) begin
                d = d - DESC_LEN;
            end
        end
        return d[4:0];
    endfunction

endpackage

@@ hdl/erp_decode.sv @@
// byte offset tracking and standard / detailed timing decode
module erp_decode (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_block_start,
    output logic             o_req_valid,
    output erp_pkg::t_timing o_req
);

    logic [6:0]       r_offset, n_offset;
    logic [7:0]       r_held [4];
    logic [7:0]       n_held [4];
    logic             r_stopped, n_stopped;
    logic             r_req_valid;
    erp_pkg::t_timing r_req, n_req;
    logic             emit;

    logic [6:0]  off;
    logic [7:0]  held [4];
    logic        stopped;
    logic [4:0]  phase;
    logic [8:0]  x_sum;
    logic [11:0] std_w;

    always_comb begin
        off     = i_block_start ? '0 : r_offset;
        stopped = i_block_start ? 1'b0 : r_stopped;
        for (int i = 0; i < 4; i++) begin
            held[i] = i_block_start ? '0 : r_held[i];
        end
        phase = erp_pkg::desc_phase(off);
        x_sum = 9'(held[0]) + erp_pkg::X_BIAS;
        std_w = {x_sum, 3'b000};

        n_offset  = off + 7'd1;
        n_held    = held;
        n_stopped = stopped;
        n_req     = '0;
        emit      = 1'b0;

        if (off >= erp_pkg::STD_FIRST && off <= erp_pkg::STD_LAST) begin
            if (!off[0]) begin
                n_held[0] = i_byte;
            end else begin
                emit           = 1'b1;
                n_req.width    = std_w;
                n_req.height   = erp_pkg::std_height(i_byte[7:6], std_w);
                n_req.refresh  = 7'(i_byte[5:0]) + erp_pkg::REFRESH_BASE;
                n_req.detailed = 1'b0;
            end
        end else if (off >= erp_pkg::DESC_FIRST && off < erp_pkg::DESC_END && !stopped) begin
            case (phase)
                erp_pkg::DESC_PH_TAG0: n_held[0] = i_byte;
                erp_pkg::DESC_PH_TAG1: begin
                    if (held[0] == 8'd0 && i_byte == 8'd0) begin
                        n_stopped = 1'b1;
                    end
                end
                erp_pkg::DESC_PH_HLO: n_held[1] = i_byte;
                erp_pkg::DESC_PH_HHI: n_held[2] = i_byte;
                erp_pkg::DESC_PH_VLO: n_held[3] = i_byte;
                erp_pkg::DESC_PH_VHI: begin
                    emit           = 1'b1;
                    n_req.width    = {held[2][7:4], held[1]};
                    n_req.height   = {i_byte[7:4], held[3]};
                    n_req.refresh  = '0;
                    n_req.detailed = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_stopped   <= 1'b0;
            r_req_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_held[i] <= '0;
            end
        end else begin
            r_req_valid <= i_valid && emit;
            if (i_valid) begin
                r_offset  <= n_offset;
                r_stopped <= n_stopped;
                r_held    <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && emit) begin
            r_req <= n_req;
        end
    end

    assign o_req_valid = r_req_valid;
    assign o_req       = r_req;

endmodule

@@ hdl/erp_table.sv @@
// resolution table memory with sequential search and append
module erp_table #(
    parameter int TABLE_DEPTH = erp_pkg::TABLE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  erp_pkg::t_timing i_req,
    output logic             o_idle,
    output logic             o_done,
    output erp_pkg::t_result o_rsp,
    input  logic             i_take
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    erp_pkg::t_tbl_state r_state, n_state;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_addr;
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_rd_vld;
    logic [23:0]         r_rdata;
    logic [23:0]         r_mem [TABLE_DEPTH];
    erp_pkg::t_timing    r_req;
    logic                r_is_new;
    logic                r_full;
    logic [5:0]          r_idx;

    logic        issue;
    logic        hit;
    logic        miss;
    logic        wr_en;
    logic [23:0] key;
    logic [8:0]  hit_idx_ext;
    logic [8:0]  new_idx_ext;

    assign key         = {r_req.width, r_req.height};
    assign hit_idx_ext = 9'(r_rd_idx);
    assign new_idx_ext = 9'(r_count);

    always_comb begin
        n_state = r_state;
        issue   = 1'b0;
        hit     = 1'b0;
        miss    = 1'b0;
        wr_en   = 1'b0;
        case (r_state)
            erp_pkg::TBL_IDLE: begin
                if (i_req_valid) begin
                    n_state = erp_pkg::TBL_SEARCH;
                end
            end
            erp_pkg::TBL_SEARCH: begin
                issue = r_addr < r_count;
                if (r_rd_vld && r_rdata == key) begin
                    hit     = 1'b1;
                    n_state = erp_pkg::TBL_DONE;
                end else if (r_count == '0 ||
                             (r_rd_vld && CNT_W'(r_rd_idx + 1'b1) == r_count)) begin
                    miss    = 1'b1;
                    wr_en   = r_count < DEPTH_C;
                    n_state = erp_pkg::TBL_DONE;
                end
            end
            erp_pkg::TBL_DONE: begin
                if (i_take) begin
                    n_state = erp_pkg::TBL_IDLE;
                end
            end
            default: n_state = erp_pkg::TBL_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= erp_pkg::TBL_IDLE;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= issue;
            if (wr_en) begin
                r_count <= r_count + 1'b1;
            end
            if (r_state == erp_pkg::TBL_IDLE) begin
                r_addr <= '0;
            end else if (issue) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == erp_pkg::TBL_IDLE && i_req_valid) begin
            r_req <= i_req;
        end
        if (issue) begin
            r_rd_idx <= r_addr;
        end
        if (hit) begin
            r_is_new <= 1'b0;
            r_full   <= 1'b0;
            r_idx    <= hit_idx_ext[5:0];
        end else if (miss) begin
            r_is_new <= wr_en;
            r_full   <= !wr_en;
            r_idx    <= wr_en ? new_idx_ext[5:0] : 6'd0;
        end
    end

    // appends only happen after the search ends, so reads never see a write in flight
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= key;
        end
        if (issue) begin
            r_rdata <= r_mem[r_addr[IDX_W-1:0]];
        end
    end

    assign o_idle            = r_state == erp_pkg::TBL_IDLE;
    assign o_done            = r_state == erp_pkg::TBL_DONE;
    assign o_rsp.timing      = r_req;
    assign o_rsp.is_new      = r_is_new;
    assign o_rsp.entry_index = r_idx;
    assign o_rsp.table_full  = r_full;

endmodule

@@ hdl/edid_resolution_parser.sv @@
// top level of the edid resolution parser: stream ports, decode, table and output register
//
// takes an edid base block one byte per item on the slave stream (tuser marks offset
// zero of a new block; after offset 127 the offset wraps by itself) and emits one item
// per decoded timing: the eight standard timings at offsets 38..53 (padding entries
// included) and detailed descriptors at 54, 72, 90 and 108 until the first descriptor
// whose first two bytes are zero. every timing is looked up in a resolution table of
// TABLE_DEPTH entries and appended when new; an item is emitted whether or not it was
// new, and a new timing that finds the table full is flagged and dropped. a byte that
// completes a timing holds off input until the table search ends and its result is
// taken into the output register; the search reads one entry per cycle through the
// single read port of the table memory, up to a hit or the last stored entry. the
// table is emptied by reset through its fill count, so no clearing pass is needed;
// block_start keeps the table. a byte is taken while a finished item still waits in
// the output register.
module edid_resolution_parser #(
    parameter int TABLE_DEPTH = erp_pkg::TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] edid_byte
    input  logic        i_s_axis_tuser,   // [0] block_start
    // decoded resolution stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [11:0] res_width, [23:12] res_height, [30:24] refresh_hz, [31] is_new,
    // [37:32] entry_index, [38] table_full, [39] zero
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser    // [0] from_detailed
);

    logic             in_accept;
    logic             req_valid;
    erp_pkg::t_timing req;
    logic             tbl_idle;
    logic             tbl_done;
    erp_pkg::t_result tbl_rsp;
    logic             take;

    logic             r_out_valid;
    erp_pkg::t_result r_out;

    // one timing in flight at a time: hold off input while decode or table is busy
    assign o_s_axis_tready = tbl_idle && !req_valid;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    erp_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (in_accept),
        .i_byte        (i_s_axis_tdata),
        .i_block_start (i_s_axis_tuser),
        .o_req_valid   (req_valid),
        .o_req         (req)
    );

    erp_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_idle      (tbl_idle),
        .o_done      (tbl_done),
        .o_rsp       (tbl_rsp),
        .i_take      (take)
    );

    // output register frees the table as soon as the slot is empty or being drained
    assign take = tbl_done && (!r_out_valid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= tbl_rsp;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.table_full, r_out.entry_index, r_out.is_new,
                              r_out.timing.refresh, r_out.timing.height,
                              r_out.timing.width};
    assign o_m_axis_tuser  = r_out.timing.detailed;

endmodule

@@ hdl/erp_checker.sv @@
// port-level checks of the edid resolution parser and their bind
module erp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    // a stalled item keeps its content
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output item changed while stalled");

    // an entry cannot be both added and refused
    a_new_or_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[31] && o_m_axis_tdata[38]))
        else $error("is_new and table_full both set");

    // a refused entry reports slot zero
    a_full_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[38] |-> o_m_axis_tdata[37:32] == 6'd0)
        else $error("table_full with nonzero entry_index");

    // refresh is zero for detailed descriptors and at least 60 for standard timings
    a_refresh_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser && o_m_axis_tdata[30:24] == 7'd0) ||
            (!o_m_axis_tuser && o_m_axis_tdata[30:24] >= 7'd60))
        else $error("refresh does not match timing kind");

endmodule

bind edid_resolution_parser erp_checker u_erp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ tb/testbench.sv @@
// self-checking testbench for the edid resolution parser: directed table, random blocks, scoreboard
module testbench;

    localparam int TBL_DEPTH    = erp_pkg::TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int ITEM_TARGET  = 1550;    // random items after the directed table
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_PCT     = 27;

    typedef enum int {
        PICK_STD_X,
        PICK_DESC_LO,
        PICK_DESC_HI
    } t_pick_kind;

    // one row of the directed table: zero filler items, then one item
    typedef struct {
        int               pre;
        logic [7:0]       data;
        logic             start;
        bit               typed;
        erp_pkg::t_result res;
    } t_stim_row;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        in_start;
    logic        out_valid;
    logic        out_ready;
    logic [39:0] out_data;
    logic        out_det;

    // predictor state
    logic [6:0]  edid_off;
    logic [7:0]  held [4];
    bit          desc_stop;
    logic [23:0] seen_res [TBL_DEPTH];
    int          seen_cnt;

    erp_pkg::t_result pending_timings [$];
    t_stim_row        dir_rows [$];
    int               mismatch_cnt;
    int               cycle_cnt;

    // traffic shaping shared with the receiver
    bit          calm;
    bit          hold_req;
    bit          hold_done;
    int          hold_left;

    edid_resolution_parser #(
        .TABLE_DEPTH(TBL_DEPTH)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_byte),
        .i_s_axis_tuser  (in_start),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data),
        .o_m_axis_tuser  (out_det)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic report(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 50) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    function automatic erp_pkg::t_result mk_res(input int w, input int h, input int rf,
                                                input bit det, input bit nw, input int idx,
                                                input bit full);
        erp_pkg::t_result r;
        r.timing.width    = 12'(w);
        r.timing.height   = 12'(h);
        r.timing.refresh  = 7'(rf);
        r.timing.detailed = det;
        r.is_new          = nw;
        r.entry_index     = 6'(idx);
        r.table_full      = full;
        return r;
    endfunction

    // search the seen-resolution table, append when new and there is room
    function automatic void lookup_res(input logic [11:0] w, input logic [11:0] h,
                                       inout erp_pkg::t_result r);
        logic [23:0] key;
        key = {w, h};
        r.is_new      = 1'b0;
        r.entry_index = '0;
        r.table_full  = 1'b0;
        for (int i = 0; i < seen_cnt; i++) begin
            if (seen_res[i] == key) begin
                r.entry_index = 6'(i);
                return;
            end
        end
        if (seen_cnt < TBL_DEPTH) begin
            seen_res[seen_cnt] = key;
            r.is_new           = 1'b1;
            r.entry_index      = 6'(seen_cnt);
            seen_cnt++;
        end else begin
            r.table_full = 1'b1;
        end
    endfunction

    // advance the parser state by one byte; returns 1 when a timing completes
    function automatic bit decode_edid_byte(input logic [7:0] b, input logic blk_start,
                                            output erp_pkg::t_result r);
        int  off;
        int  wi;
        int  hi;
        bit  hit;
        logic [4:0] ph;
        hit = 1'b0;
        r   = '0;
        if (blk_start) begin
            edid_off  = '0;
            held      = '{default: 8'h00};
            desc_stop = 1'b0;
        end
        off = int'(edid_off);
        if (off >= int'(erp_pkg::STD_FIRST) && off <= int'(erp_pkg::STD_LAST)) begin
            if (off % 2 == 0) begin
                held[0] = b;
            end else begin
                wi = (int'(held[0]) + 31) * 8;
                case (b[7:6])
                    erp_pkg::ASPECT_16_10: hi = (wi / 16) * 10;
                    erp_pkg::ASPECT_4_3:   hi = (wi / 4) * 3;
                    erp_pkg::ASPECT_5_4:   hi = (wi / 5) * 4;
                    default:               hi = (wi / 16) * 9;
                endcase
                r.timing.width    = 12'(wi);
                r.timing.height   = 12'(hi);
                r.timing.refresh  = 7'(int'(b[5:0]) + 60);
                r.timing.detailed = 1'b0;
                lookup_res(r.timing.width, r.timing.height, r);
                hit = 1'b1;
            end
        end else if (off >= int'(erp_pkg::DESC_FIRST) && off < int'(erp_pkg::DESC_END)
                     && !desc_stop) begin
            ph = 5'((off - int'(erp_pkg::DESC_FIRST)) % int'(erp_pkg::DESC_LEN));
            case (ph)
                erp_pkg::DESC_PH_TAG0: held[0] = b;
                erp_pkg::DESC_PH_TAG1: begin
                    // a descriptor tagged 00 00 ends the scan for this block
                    if (held[0] == 8'h00 && b == 8'h00) begin
                        desc_stop = 1'b1;
                    end
                end
                erp_pkg::DESC_PH_HLO: held[1] = b;
                erp_pkg::DESC_PH_HHI: held[2] = b;
                erp_pkg::DESC_PH_VLO: held[3] = b;
                erp_pkg::DESC_PH_VHI: begin
                    r.timing.width    = {held[2][7:4], held[1]};
                    r.timing.height   = {b[7:4], held[3]};
                    r.timing.refresh  = '0;
                    r.timing.detailed = 1'b1;
                    lookup_res(r.timing.width, r.timing.height, r);
                    hit = 1'b1;
                end
                default: ;
            endcase
        end
        edid_off = 7'(off + 1);
        return hit;
    endfunction

    // byte values biased toward a few common timings so that table hits happen
    function automatic logic [7:0] biased_byte(input t_pick_kind kind);
        logic [7:0] r;
        int         sel;
        r   = 8'($urandom);
        sel = $urandom_range(4, 0);
        if (sel != 4) begin
            case (kind)
                PICK_STD_X: begin
                    case (sel)
                        0:       r = 8'h01;
                        1:       r = 8'h31;
                        2:       r = 8'h81;
                        default: r = 8'hD1;
                    endcase
                end
                PICK_DESC_LO: begin
                    case (sel)
                        0:       r = 8'h00;
                        1:       r = 8'h80;
                        2:       r = 8'h20;
                        default: r = 8'hFF;
                    endcase
                end
                default: begin
                    case (sel)
                        0:       r[7:4] = 4'h0;
                        1:       r[7:4] = 4'h2;
                        2:       r[7:4] = 4'h5;
                        default: r[7:4] = 4'h7;
                    endcase
                end
            endcase
        end
        return r;
    endfunction

    task automatic add_row(input int pre, input logic [7:0] data, input logic start,
                           input bit typed, input erp_pkg::t_result res);
        t_stim_row row;
        row.pre   = pre;
        row.data  = data;
        row.start = start;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endtask

    // offer one item, wait for the handshake, then queue what it should produce
    task automatic send_byte(input logic [7:0] b, input logic st, input bit typed,
                             input erp_pkg::t_result tres);
        erp_pkg::t_result pred;
        bit               hit;
        while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
            @(negedge clk);
            in_valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_start <= st;
        do @(posedge clk); while (!in_ready);
        hit = decode_edid_byte(b, st, pred);
        if (typed) begin
            pending_timings.push_back(tres);
        end else if (hit) begin
            pending_timings.push_back(pred);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_timings.size() != 0) @(posedge clk);
    endtask

    task automatic check_timing(input logic [39:0] d, input logic det);
        erp_pkg::t_result want;
        if (pending_timings.size() == 0) begin
            report($sformatf("unexpected item, data %h detailed %b", d, det));
            return;
        end
        want = pending_timings.pop_front();
        if (d[11:0] != want.timing.width)
            report($sformatf("res_width got %0d want %0d", d[11:0], want.timing.width));
        if (d[23:12] != want.timing.height)
            report($sformatf("res_height got %0d want %0d", d[23:12], want.timing.height));
        if (d[30:24] != want.timing.refresh)
            report($sformatf("refresh_hz got %0d want %0d", d[30:24], want.timing.refresh));
        if (det != want.timing.detailed)
            report($sformatf("from_detailed got %0d want %0d", det, want.timing.detailed));
        if (d[31] != want.is_new)
            report($sformatf("is_new got %0d want %0d", d[31], want.is_new));
        if (d[37:32] != want.entry_index)
            report($sformatf("entry_index got %0d want %0d", d[37:32], want.entry_index));
        if (d[38] != want.table_full)
            report($sformatf("table_full got %0d want %0d", d[38], want.table_full));
        if (d[39] != 1'b0)
            report("padding bit of tdata set");
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_timing(out_data, out_det);
        end
    end

    // receiver: random stalls, one long hold-off on request, none while calm
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99, 0) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int         blk;
        int         len;
        int         rand_items;
        int         ph;
        bit         st0;
        bit         zero_tag;
        logic [7:0] b;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_byte      = '0;
        in_start     = 1'b0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        hold_left    = 0;
        mismatch_cnt = 0;
        cycle_cnt    = 0;
        edid_off     = '0;
        held         = '{default: 8'h00};
        desc_stop    = 1'b0;
        seen_cnt     = 0;
        rand_items   = 0;
        zero_tag     = 1'b0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed block on an empty table
        add_row(0,  8'hFF, 1'b1, 1'b0, '0);                   // header byte, no item out
        add_row(37, 8'h00, 1'b0, 1'b0, '0);                   // first standard timing
        add_row(0,  8'h00, 1'b0, 1'b1, mk_res(248, 150, 60, 0, 1, 0, 0));
        add_row(0,  8'hFF, 1'b0, 1'b0, '0);                   // widest x, 16:9, top refresh
        add_row(0,  8'hFF, 1'b0, 1'b1, mk_res(2288, 1287, 123, 0, 1, 1, 0));
        add_row(0,  8'h01, 1'b0, 1'b0, '0);                   // padding entry is decoded
        add_row(0,  8'h01, 1'b0, 1'b1, mk_res(256, 160, 61, 0, 1, 2, 0));
        add_row(0,  8'h00, 1'b0, 1'b0, '0);                   // 4:3
        add_row(0,  8'h40, 1'b0, 1'b0, '0);
        add_row(0,  8'h00, 1'b0, 1'b0, '0);                   // 5:4
        add_row(0,  8'h80, 1'b0, 1'b0, '0);
        add_row(0,  8'h00, 1'b0, 1'b0, '0);                   // repeat of slot 0
        add_row(0,  8'h00, 1'b0, 1'b1, mk_res(248, 150, 60, 0, 0, 0, 0));
        add_row(0,  8'hD1, 1'b0, 1'b0, '0);                   // 1920x1080
        add_row(0,  8'hC0, 1'b0, 1'b0, '0);
        add_row(2,  8'hFF, 1'b0, 1'b0, '0);                   // descriptor of all ones
        add_row(0,  8'hFF, 1'b0, 1'b0, '0);
        add_row(0,  8'hFF, 1'b0, 1'b0, '0);
        add_row(1,  8'hFF, 1'b0, 1'b0, '0);
        add_row(0,  8'hFF, 1'b0, 1'b0, '0);
        add_row(1,  8'hFF, 1'b0, 1'b1, mk_res(4095, 4095, 0, 1, 1, 6, 0));
        add_row(10, 8'h00, 1'b0, 1'b0, '0);                   // tag 00 01 does not stop
        add_row(0,  8'h01, 1'b0, 1'b0, '0);
        add_row(5,  8'h00, 1'b0, 1'b1, mk_res(0, 0, 0, 1, 1, 7, 0));
        add_row(10, 8'h00, 1'b0, 1'b0, '0);                   // tag 00 00 stops the scan
        add_row(0,  8'h00, 1'b0, 1'b0, '0);
        add_row(5,  8'hFF, 1'b0, 1'b0, '0);                   // would complete, but stopped
        add_row(0,  8'h5A, 1'b1, 1'b0, '0);                   // restart in mid-block

        foreach (dir_rows[i]) begin
            repeat (dir_rows[i].pre) send_byte(8'h00, 1'b0, 1'b0, '0);
            send_byte(dir_rows[i].data, dir_rows[i].start, dir_rows[i].typed,
                      dir_rows[i].res);
        end

        // random blocks: mostly whole blocks, some running on across the wrap,
        // some cut short by an early block start
        blk = 0;
        while (rand_items < ITEM_TARGET) begin
            blk++;
            len = 128;
            st0 = 1'b1;
            ph  = $urandom_range(99, 0);
            if (ph < 12 && edid_off == 0) begin
                st0 = 1'b0;
            end else if (ph >= 85) begin
                len = $urandom_range(127, 1);
            end
            if (blk == 6) begin
                drain_results();
            end
            calm = (blk == 9 || blk == 10);
            for (int o = 0; o < len; o++) begin
                if (o >= 38 && o <= 53) begin
                    b = (o % 2 == 1) ? 8'($urandom) : biased_byte(PICK_STD_X);
                end else if (o >= 54 && o < 126) begin
                    ph = (o - 54) % 18;
                    if (ph == 0) begin
                        zero_tag = ($urandom_range(99, 0) < 20);
                    end
                    case (ph)
                        0: b = (zero_tag || $urandom_range(3, 0) == 0) ? 8'h00 : 8'($urandom);
                        1: b = zero_tag ? 8'h00 : 8'($urandom);
                        2, 5: b = biased_byte(PICK_DESC_LO);
                        4, 7: b = biased_byte(PICK_DESC_HI);
                        default: b = 8'($urandom);
                    endcase
                end else begin
                    b = 8'($urandom);
                end
                if (blk == 3 && o == 40) begin
                    hold_req = 1'b1;
                end
                rand_items++;
                send_byte(b, (o == 0) ? st0 : 1'b0, 1'b0, '0);
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/erp_pkg.sv
hdl/erp_decode.sv
hdl/erp_table.sv
hdl/edid_resolution_parser.sv
hdl/erp_checker.sv
tb/testbench.sv
